// ----- rtl/ad85_pkg.sv -----
package ad85_pkg;

  // Stream status codes
  localparam logic [1:0] ST_RUN = 2'd0;
  localparam logic [1:0] ST_OK  = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  localparam logic [6:0] RADIX = 7'd85;

  // Job queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // One decoded item: up to four bytes, most significant first
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  nbytes;
    logic [1:0]  status;
    logic [31:0] base;
  } job_t;

  // Scale for padding a group of n digits with the top digit: 85^(5-n)
  function automatic logic [31:0] pad_scale(input logic [2:0] n);
    logic [31:0] s;
    case (n)
      3'd2:    s = 32'd614125;
      3'd3:    s = 32'd7225;
      3'd4:    s = 32'd85;
      default: s = 32'd1;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/ad85_front.sv -----
module ad85_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               acc_en,
  input  logic [7:0]         char_in,
  input  logic               end_in,
  output ad85_pkg::job_t     job
);

  logic [31:0] cap_r;
  logic [31:0] gv_r, gv_nxt;
  logic [2:0]  dc_r, dc_nxt;
  logic [31:0] wc_r, wc_nxt;
  logic        fin_r, fin_nxt;
  logic [1:0]  fs_r, fs_nxt;

  logic        is_ws, is_digit, ovf, fits4, room_pos;
  logic [6:0]  digit;
  logic [38:0] acc;
  logic [31:0] scale, padv, room;
  logic        do_flush;
  logic [2:0]  fl_have, fl_max, fl_n;
  logic [31:0] fl_val;

  // Classify the character
  always_comb begin
    is_ws = (char_in == ad85_pkg::CH_SPACE) || (char_in == ad85_pkg::CH_TAB) ||
            (char_in == ad85_pkg::CH_CR) || (char_in == ad85_pkg::CH_LF) ||
            (char_in == ad85_pkg::CH_FF) || (char_in == ad85_pkg::CH_NUL);
    is_digit = (char_in >= ad85_pkg::CH_BANG) && (char_in <= ad85_pkg::CH_U);
    digit    = 7'(char_in - ad85_pkg::CH_BANG);
  end

  // Accumulate a digit and pad a short group (85^k - 1 equals k pad digits)
  always_comb begin
    acc   = ({7'd0, gv_r} * {32'd0, ad85_pkg::RADIX}) + {32'd0, digit};
    ovf   = (acc[38:32] != 7'd0);
    scale = ad85_pkg::pad_scale(dc_r);
    padv  = 32'(gv_r * scale) + (scale - 32'd1);
  end

  // Capacity checks
  always_comb begin
    room_pos = (wc_r < cap_r);
    room     = cap_r - wc_r;
    fits4    = ({1'b0, wc_r} + 33'd4) <= {1'b0, cap_r};
  end

  // Decode one accepted item
  always_comb begin
    gv_nxt   = gv_r;
    dc_nxt   = dc_r;
    wc_nxt   = wc_r;
    fin_nxt  = fin_r;
    fs_nxt   = fs_r;
    job.word   = 32'd0;
    job.nbytes = 3'd0;
    job.base   = wc_r;
    do_flush = 1'b0;
    fl_have  = dc_r;
    fl_val   = padv;
    fl_max   = 3'd0;
    fl_n     = 3'd0;

    if (!fin_r) begin
      if (end_in || (char_in == ad85_pkg::CH_TILDE)) begin
        do_flush = 1'b1;
      end else if (is_ws) begin
        // skip
      end else if ((char_in == ad85_pkg::CH_Z) && (dc_r == 3'd0)) begin
        if (!fits4) begin
          do_flush = 1'b1;
        end else begin
          job.nbytes = 3'd4;
          wc_nxt     = wc_r + 32'd4;
        end
      end else if (!is_digit || ovf) begin
        fin_nxt = 1'b1;
        fs_nxt  = ad85_pkg::ST_BAD;
        gv_nxt  = 32'd0;
        dc_nxt  = 3'd0;
      end else if (dc_r != 3'd4) begin
        gv_nxt = acc[31:0];
        dc_nxt = dc_r + 3'd1;
      end else if (!fits4) begin
        do_flush = 1'b1;
        fl_have  = 3'd5;
        fl_val   = acc[31:0];
      end else begin
        job.word   = acc[31:0];
        job.nbytes = 3'd4;
        wc_nxt     = wc_r + 32'd4;
        gv_nxt     = 32'd0;
        dc_nxt     = 3'd0;
      end
    end

    // Close the stream, emitting what the capacity allows
    if (do_flush) begin
      fin_nxt = 1'b1;
      gv_nxt  = 32'd0;
      dc_nxt  = 3'd0;
      if (fl_have == 3'd1) begin
        fs_nxt = ad85_pkg::ST_BAD;
      end else begin
        fs_nxt = ad85_pkg::ST_OK;
        if (fl_have >= 3'd2) begin
          fl_max = (fl_have == 3'd5) ? 3'd4 : fl_have - 3'd1;
          if (!room_pos) begin
            fl_n = 3'd0;
          end else if (room >= {29'd0, fl_max}) begin
            fl_n = fl_max;
          end else begin
            fl_n = room[2:0];
          end
          job.word   = fl_val;
          job.nbytes = fl_n;
          wc_nxt     = wc_r + {29'd0, fl_n};
        end
      end
    end

    job.status = fin_nxt ? fs_nxt : ad85_pkg::ST_RUN;

    // Drop stream state after an end item
    if (end_in) begin
      gv_nxt  = 32'd0;
      dc_nxt  = 3'd0;
      wc_nxt  = 32'd0;
      fin_nxt = 1'b0;
      fs_nxt  = ad85_pkg::ST_RUN;
    end
  end

  // Hold stream state and capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 32'hFFFF_FFFF;
      gv_r  <= 32'd0;
      dc_r  <= 3'd0;
      wc_r  <= 32'd0;
      fin_r <= 1'b0;
      fs_r  <= ad85_pkg::ST_RUN;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (acc_en) begin
        gv_r  <= gv_nxt;
        dc_r  <= dc_nxt;
        wc_r  <= wc_nxt;
        fin_r <= fin_nxt;
        fs_r  <= fs_nxt;
      end
    end
  end

endmodule

// ----- rtl/ad85_queue.sv -----
module ad85_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  ad85_pkg::job_t     wr_job,
  output logic               q_full,
  input  logic               rd_en,
  output ad85_pkg::job_t     rd_job,
  output logic               q_nonempty
);

  ad85_pkg::job_t                  mem_r [ad85_pkg::Q_DEPTH];
  logic [ad85_pkg::Q_AW-1:0]       wp_r, rp_r;
  logic [ad85_pkg::Q_CW-1:0]       cnt_r;
  logic                            do_wr, do_rd;

  assign q_full     = (cnt_r == ad85_pkg::Q_CW'(ad85_pkg::Q_DEPTH));
  assign q_nonempty = (cnt_r != '0);
  assign do_wr      = wr_en && !q_full;
  assign do_rd      = rd_en && q_nonempty;
  assign rd_job     = mem_r[rp_r];

  // Store jobs
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_job;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= rp_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/ad85_back.sv -----
module ad85_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ad85_pkg::job_t     q_job,
  input  logic               q_nonempty,
  output logic               q_take,
  input  logic               pop,
  output logic               empty,
  output logic [7:0]         byte_out,
  output logic               byte_valid,
  output logic [1:0]         status,
  output logic [31:0]        bytes_total,
  output logic               last
);

  ad85_pkg::job_t cur_r;
  logic           cur_v_r;
  logic [1:0]     idx_r;
  logic [2:0]     cnt;
  logic [31:0]    word_sh;
  logic           done;

  // Present the current result
  always_comb begin
    cnt         = (cur_r.nbytes == 3'd0) ? 3'd1 : cur_r.nbytes;
    last        = (({1'b0, idx_r} + 3'd1) == cnt);
    byte_valid  = (cur_r.nbytes != 3'd0);
    word_sh     = cur_r.word >> {2'd3 - idx_r, 3'b000};
    byte_out    = byte_valid ? word_sh[7:0] : 8'd0;
    status      = cur_r.status;
    bytes_total = cur_r.base + (byte_valid ? {30'd0, idx_r} + 32'd1 : 32'd0);
    empty       = !cur_v_r;
    done        = pop && cur_v_r && last;
    q_take      = q_nonempty && (!cur_v_r || done);
  end

  // Load a job, step through its results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (q_take) begin
        cur_v_r <= 1'b1;
        idx_r   <= 2'd0;
      end else if (done) begin
        cur_v_r <= 1'b0;
        idx_r   <= 2'd0;
      end else if (pop && cur_v_r) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_take) begin
      cur_r <= q_job;
    end
  end

endmodule

// ----- rtl/ascii85_stream_decoder.sv -----
// Channel  | Handshake             | Payload
// ---------+-----------------------+---------------------------------------------
// input    | push / full           | in_char_in[7:0], in_end_of_input
// result   | pop / empty           | out_byte_out[7:0], out_byte_valid, out_status[1:0],
//          |                       | out_bytes_total[31:0], out_last
// config   | cfg_wr_en             | cfg_wr_data[31:0] (output capacity)
//
// The front decodes one character per cycle while full is low, writing one job per
// character into a four-entry queue. The back hands out one result per cycle while pop
// is held: an item gives one to four results, so the result port sets the sustained rate.
// A first result passes through the queue memory and then the back's job register.
// Reset is synchronous, active low; full rises while the queue holds four jobs.
module ascii85_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_char_in,
  input  logic        in_end_of_input,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  out_byte_out,
  output logic        out_byte_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_bytes_total,
  output logic        out_last
);

  ad85_pkg::job_t front_job, q_job;
  logic           acc_en, q_nonempty, q_take, q_full;

  assign full   = q_full;
  assign acc_en = push && !q_full;

  ad85_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .acc_en      (acc_en),
    .char_in     (in_char_in),
    .end_in      (in_end_of_input),
    .job         (front_job)
  );

  ad85_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (acc_en),
    .wr_job     (front_job),
    .q_full     (q_full),
    .rd_en      (q_take),
    .rd_job     (q_job),
    .q_nonempty (q_nonempty)
  );

  ad85_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_job       (q_job),
    .q_nonempty  (q_nonempty),
    .q_take      (q_take),
    .pop         (pop),
    .empty       (empty),
    .byte_out    (out_byte_out),
    .byte_valid  (out_byte_valid),
    .status      (out_status),
    .bytes_total (out_bytes_total),
    .last        (out_last)
  );

endmodule
